### rtl/bpc_pkg.sv
// ============================================================================
// Barometric compensation package
// Shared constants, register indexes, pipeline sideband type and a helper.
// ============================================================================
package bpc_pkg;

  localparam int DIV_W = 32;

  localparam logic [2:0] REG_AC1     = 3'd0;
  localparam logic [2:0] REG_AC2     = 3'd1;
  localparam logic [2:0] REG_AC3     = 3'd2;
  localparam logic [2:0] REG_AC4     = 3'd3;
  localparam logic [2:0] REG_AC5_AC6 = 3'd4;
  localparam logic [2:0] REG_B1_B2   = 3'd5;
  localparam logic [2:0] REG_MC_MD   = 3'd6;
  localparam logic [2:0] REG_OSS     = 3'd7;

  localparam logic [15:0] RST_AC1     = 16'd408;
  localparam logic [15:0] RST_AC2     = 16'hFFB8;
  localparam logic [15:0] RST_AC3     = 16'hC7D1;
  localparam logic [15:0] RST_AC4     = 16'd32741;
  localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
  localparam logic [31:0] RST_B1_B2   = 32'd405667844;
  localparam logic [31:0] RST_MC_MD   = 32'd3724086068;

  localparam logic [31:0] C_B5_OFS   = 32'd4000;
  localparam logic [31:0] C_P_K1     = 32'd3038;
  localparam logic signed [15:0] C_P_K2 = -16'sd7357;
  localparam logic [31:0] C_P_K3     = 32'd3791;
  localparam logic [31:0] C_AC4_OFS  = 32'h0000_8000;
  localparam logic [15:0] C_B7_SCALE = 16'd50000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIVZ  = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;

  typedef struct packed {
    logic        vld;
    logic        dz;
    logic [31:0] a;
    logic [31:0] b;
  } side_t;

  // Signed division by 2**k, truncating toward zero.
  function automatic logic [31:0] sdiv_p2(input logic [31:0] v, input logic [4:0] k);
    logic [31:0] bias;
    bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    return $unsigned($signed(v + bias) >>> k);
  endfunction

endpackage

### rtl/barometric_pressure_compensation_unit.sv
// ============================================================================
// Barometric pressure compensation unit
// Integer temperature and pressure compensation as a fully pipelined datapath.
// ============================================================================
// Usage:
// A request on the in_ channel carries one raw temperature and one raw
// pressure count. Each request yields exactly one result on the out_ channel
// with temperature in tenths of a degree, pressure in pascals and a status.
// The cfg_ channel writes calibration registers; cfg_ready is always high,
// and writes are expected only while no request is in flight.
// The two 33-stage dividers (an input stage plus one stage per quotient bit)
// make up most of the pipeline stages.
// Throughput is one request per cycle unless stalled; all stages share one enable.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated, and it resumes when the
// result is taken.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// default calibration values.
// ============================================================================
module barometric_pressure_compensation_unit
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_raw_temp,
  input  logic [23:0]        in_raw_press,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_temperature_deci,
  output logic [17:0]        out_pressure_pa,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [15:0] ac1_r, ac2_r, ac3_r, ac4_r;
  logic [31:0] ac56_r, b12_r, mcmd_r;
  logic [1:0]  oss_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_r  <= RST_AC1;
      ac2_r  <= RST_AC2;
      ac3_r  <= RST_AC3;
      ac4_r  <= RST_AC4;
      ac56_r <= RST_AC5_AC6;
      b12_r  <= RST_B1_B2;
      mcmd_r <= RST_MC_MD;
      oss_r  <= 2'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AC1:     ac1_r  <= cfg_data[15:0];
        REG_AC2:     ac2_r  <= cfg_data[15:0];
        REG_AC3:     ac3_r  <= cfg_data[15:0];
        REG_AC4:     ac4_r  <= cfg_data[15:0];
        REG_AC5_AC6: ac56_r <= cfg_data;
        REG_B1_B2:   b12_r  <= cfg_data;
        REG_MC_MD:   mcmd_r <= cfg_data;
        REG_OSS:     oss_r  <= cfg_data[1:0];
        default:     ;
      endcase
    end
  end

  logic [15:0] ac5, ac6, b1, b2, mc, md;
  assign ac5 = ac56_r[31:16];
  assign ac6 = ac56_r[15:0];
  assign b1  = b12_r[31:16];
  assign b2  = b12_r[15:0];
  assign mc  = mcmd_r[31:16];
  assign md  = mcmd_r[15:0];

  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stage registers.
  logic        s1_vld_r, s2_vld_r, s3_vld_r;
  logic [15:0] s1_ut_r;
  logic [18:0] s1_up_r, s2_up_r, s3_up_r;
  logic [31:0] s2_m1_r, s3_x1_r, s3_d_r;

  logic        s5_vld_r, s6_vld_r, s7_vld_r, s8_vld_r, s9_vld_r, s10_vld_r;
  logic        s5_dz_r, s6_dz_r, s7_dz_r, s8_dz_r, s9_dz_r, s10_dz_r;
  logic [18:0] s5_up_r, s6_up_r, s7_up_r, s8_up_r, s9_up_r;
  logic [31:0] s5_t_r, s6_t_r, s7_t_r, s8_t_r, s9_t_r, s10_t_r;
  logic [31:0] s5_b6_r;
  logic [31:0] s6_b6sq_r, s6_ac2b6_r, s6_ac3b6_r;
  logic [31:0] s7_sq_r, s7_x2a_r, s7_x1c_r;
  logic [31:0] s8_b2sq_r, s8_b1sq_r, s8_x2a_r, s8_x1c_r;
  logic [31:0] s9_b3_r, s9_x3b_r;
  logic [31:0] s10_b4p_r, s10_b7_r;

  logic        s12_vld_r, s13_vld_r;
  logic        s12_dz_r, s13_dz_r;
  logic [31:0] s12_t_r, s13_t_r, s12_p_r, s13_p_r, s12_m7_r, s13_m7_r;
  logic [31:0] s12_sqp_r, s13_prod_r;

  logic signed [15:0] temp_r;
  logic [17:0]        press_r;
  logic [1:0]         status_r;

  // Next values.
  logic [18:0] s1_up_nxt;
  logic [31:0] s2_m1_nxt, s3_x1_nxt, s3_d_nxt;
  logic [31:0] s5_t_nxt, s5_b6_nxt, s5_b5;
  logic [31:0] s6_b6sq_nxt, s6_ac2b6_nxt, s6_ac3b6_nxt;
  logic [31:0] s8_b2sq_nxt, s8_b1sq_nxt;
  logic [31:0] s9_b3_nxt, s9_x3b_nxt;
  logic [31:0] s10_b4p_nxt, s10_b7_nxt;
  logic [31:0] s12_p_nxt, s12_sqp_nxt, s12_m7_nxt, s13_prod_nxt;
  logic signed [15:0] temp_nxt;
  logic [17:0]        press_nxt;
  logic [1:0]         status_nxt;

  logic [DIV_W-1:0] d1_num, d1_den, d1_quo, d2_num, d2_den, d2_quo;
  side_t            d1_in, d1_out, d2_in, d2_out;

  always_comb begin
    logic [23:0]        sh;
    logic signed [16:0] dt, a5s;
    logic signed [33:0] pr;
    sh        = in_raw_press >> (4'd8 - {2'b00, oss_r});
    s1_up_nxt = sh[18:0];
    dt        = $signed({1'b0, s1_ut_r}) - $signed({1'b0, ac6});
    a5s       = $signed({1'b0, ac5});
    pr        = dt * a5s;
    s2_m1_nxt = pr[31:0];
    s3_x1_nxt = sdiv_p2(s2_m1_r, 5'd15);
    s3_d_nxt  = s3_x1_nxt + {{16{md[15]}}, md};
  end

  // First divider: x2 = (mc * 2048) / (x1 + md), done on magnitudes.
  always_comb begin
    logic [31:0] ns;
    ns         = {{5{mc[15]}}, mc, 11'b0};
    d1_num     = mc[15] ? (32'd0 - ns) : ns;
    d1_den     = (s3_d_r == 32'd0) ? 32'd1 : (s3_d_r[31] ? (32'd0 - s3_d_r) : s3_d_r);
    d1_in.vld  = s3_vld_r;
    d1_in.dz   = (s3_d_r == 32'd0);
    d1_in.a    = s3_x1_r;
    d1_in.b    = {mc[15] ^ s3_d_r[31], 12'b0, s3_up_r};
  end

  bpc_div u_div_x2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_num   (d1_num),
    .in_den   (d1_den),
    .in_side  (d1_in),
    .quo      (d1_quo),
    .out_side (d1_out)
  );

  always_comb begin
    logic signed [63:0] m64;
    logic signed [47:0] m2, m3;
    logic [31:0]        x2;
    x2        = d1_out.b[31] ? (32'd0 - d1_quo) : d1_quo;
    s5_b5     = d1_out.a + x2;
    s5_t_nxt  = sdiv_p2(s5_b5 + 32'd8, 5'd4);
    s5_b6_nxt = s5_b5 - C_B5_OFS;
    m64          = $signed(s5_b6_r) * $signed(s5_b6_r);
    s6_b6sq_nxt  = m64[31:0];
    m2           = $signed(ac2_r) * $signed(s5_b6_r);
    s6_ac2b6_nxt = m2[31:0];
    m3           = $signed(ac3_r) * $signed(s5_b6_r);
    s6_ac3b6_nxt = m3[31:0];
  end

  always_comb begin
    logic signed [47:0] mb2, mb1;
    logic [31:0]        x1, x3, v, v2, x2b;
    mb2         = $signed(b2) * $signed(s7_sq_r);
    s8_b2sq_nxt = mb2[31:0];
    mb1         = $signed(b1) * $signed(s7_sq_r);
    s8_b1sq_nxt = mb1[31:0];
    x1          = sdiv_p2(s8_b2sq_r, 5'd11);
    x3          = x1 + s8_x2a_r;
    v           = {{14{ac1_r[15]}}, ac1_r, 2'b00} + x3;
    v2          = v << oss_r;
    s9_b3_nxt   = sdiv_p2(v2 + 32'd2, 5'd2);
    x2b         = sdiv_p2(s8_b1sq_r, 5'd16);
    s9_x3b_nxt  = sdiv_p2(s8_x1c_r + x2b + 32'd2, 5'd2);
  end

  always_comb begin
    logic [47:0] m4, m7;
    logic [15:0] sc;
    m4          = ac4_r * (s9_x3b_r + C_AC4_OFS);
    s10_b4p_nxt = m4[31:0];
    sc          = C_B7_SCALE >> oss_r;
    m7          = ({13'b0, s9_up_r} - s9_b3_r) * sc;
    s10_b7_nxt  = m7[31:0];
  end

  // Second divider: unsigned b7 / b4, with the b7 doubling placed by b7's MSB.
  always_comb begin
    logic [16:0] b4;
    b4        = s10_b4p_r[31:15];
    d2_num    = s10_b7_r[31] ? s10_b7_r : {s10_b7_r[30:0], 1'b0};
    d2_den    = (b4 == 17'd0) ? 32'd1 : {15'b0, b4};
    d2_in.vld = s10_vld_r;
    d2_in.dz  = s10_dz_r || (b4 == 17'd0);
    d2_in.a   = s10_t_r;
    d2_in.b   = {31'b0, s10_b7_r[31]};
  end

  bpc_div u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_num   (d2_num),
    .in_den   (d2_den),
    .in_side  (d2_in),
    .quo      (d2_quo),
    .out_side (d2_out)
  );

  always_comb begin
    logic [31:0]        pd;
    logic signed [47:0] sq, mk;
    logic [63:0]        m3;
    logic [31:0]        x1, x2, s, pf;
    logic               clamp;
    s12_p_nxt    = d2_out.b[0] ? {d2_quo[30:0], 1'b0} : d2_quo;
    pd           = sdiv_p2(s12_p_nxt, 5'd8);
    sq           = $signed(pd[23:0]) * $signed(pd[23:0]);
    s12_sqp_nxt  = sq[31:0];
    mk           = $signed(s12_p_nxt) * C_P_K2;
    s12_m7_nxt   = mk[31:0];
    m3           = s12_sqp_r * C_P_K1;
    s13_prod_nxt = m3[31:0];

    x1    = sdiv_p2(s13_prod_r, 5'd16);
    x2    = sdiv_p2(s13_m7_r, 5'd16);
    s     = sdiv_p2(x1 + x2 + C_P_K3, 5'd4);
    pf    = s13_p_r + s;
    clamp = 1'b0;
    if ($signed(s13_t_r) > 32'sd32767) begin
      temp_nxt = 16'sh7FFF;
      clamp    = 1'b1;
    end else if ($signed(s13_t_r) < -32'sd32768) begin
      temp_nxt = -16'sh8000;
      clamp    = 1'b1;
    end else begin
      temp_nxt = s13_t_r[15:0];
    end
    if ($signed(pf) > 32'sd262143) begin
      press_nxt = 18'h3FFFF;
      clamp     = 1'b1;
    end else if (pf[31]) begin
      press_nxt = 18'd0;
      clamp     = 1'b1;
    end else begin
      press_nxt = pf[17:0];
    end
    status_nxt = clamp ? ST_CLAMP : ST_OK;
    if (s13_dz_r) begin
      temp_nxt   = '0;
      press_nxt  = '0;
      status_nxt = ST_DIVZ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0; s2_vld_r <= 1'b0; s3_vld_r <= 1'b0;
      s5_vld_r <= 1'b0; s6_vld_r <= 1'b0; s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0; s9_vld_r <= 1'b0; s10_vld_r <= 1'b0;
      s12_vld_r <= 1'b0; s13_vld_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s5_vld_r    <= d1_out.vld;
      s6_vld_r    <= s5_vld_r;
      s7_vld_r    <= s6_vld_r;
      s8_vld_r    <= s7_vld_r;
      s9_vld_r    <= s8_vld_r;
      s10_vld_r   <= s9_vld_r;
      s12_vld_r   <= d2_out.vld;
      s13_vld_r   <= s12_vld_r;
      out_valid_r <= s13_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ut_r <= in_raw_temp;
      s1_up_r <= s1_up_nxt;
      s2_up_r <= s1_up_r;
      s2_m1_r <= s2_m1_nxt;
      s3_up_r <= s2_up_r;
      s3_x1_r <= s3_x1_nxt;
      s3_d_r  <= s3_d_nxt;

      s5_dz_r <= d1_out.dz;
      s5_up_r <= d1_out.b[18:0];
      s5_t_r  <= s5_t_nxt;
      s5_b6_r <= s5_b6_nxt;

      s6_dz_r    <= s5_dz_r;
      s6_up_r    <= s5_up_r;
      s6_t_r     <= s5_t_r;
      s6_b6sq_r  <= s6_b6sq_nxt;
      s6_ac2b6_r <= s6_ac2b6_nxt;
      s6_ac3b6_r <= s6_ac3b6_nxt;

      s7_dz_r  <= s6_dz_r;
      s7_up_r  <= s6_up_r;
      s7_t_r   <= s6_t_r;
      s7_sq_r  <= sdiv_p2(s6_b6sq_r, 5'd12);
      s7_x2a_r <= sdiv_p2(s6_ac2b6_r, 5'd11);
      s7_x1c_r <= sdiv_p2(s6_ac3b6_r, 5'd13);

      s8_dz_r   <= s7_dz_r;
      s8_up_r   <= s7_up_r;
      s8_t_r    <= s7_t_r;
      s8_b2sq_r <= s8_b2sq_nxt;
      s8_b1sq_r <= s8_b1sq_nxt;
      s8_x2a_r  <= s7_x2a_r;
      s8_x1c_r  <= s7_x1c_r;

      s9_dz_r  <= s8_dz_r;
      s9_up_r  <= s8_up_r;
      s9_t_r   <= s8_t_r;
      s9_b3_r  <= s9_b3_nxt;
      s9_x3b_r <= s9_x3b_nxt;

      s10_dz_r  <= s9_dz_r;
      s10_t_r   <= s9_t_r;
      s10_b4p_r <= s10_b4p_nxt;
      s10_b7_r  <= s10_b7_nxt;

      s12_dz_r  <= d2_out.dz;
      s12_t_r   <= d2_out.a;
      s12_p_r   <= s12_p_nxt;
      s12_sqp_r <= s12_sqp_nxt;
      s12_m7_r  <= s12_m7_nxt;

      s13_dz_r   <= s12_dz_r;
      s13_t_r    <= s12_t_r;
      s13_p_r    <= s12_p_r;
      s13_m7_r   <= s12_m7_r;
      s13_prod_r <= s13_prod_nxt;

      temp_r   <= temp_nxt;
      press_r  <= press_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_temperature_deci = temp_r;
  assign out_pressure_pa      = press_r;
  assign out_status           = status_r;

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while output stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_DIVZ ||
                   out_status == ST_CLAMP))
    else $error("unknown status code");

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DIVZ) |-> (out_temperature_deci == 16'sd0 &&
                                              out_pressure_pa == 18'd0))
    else $error("division fault with nonzero result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && s13_vld_r) |=> s13_vld_r)
    else $error("pipeline lost a request during stall");
`endif

endmodule

### rtl/bpc_div.sv
// ============================================================================
// Pipelined unsigned divider
// One quotient bit per stage, sideband carried alongside, shared clock enable.
// ============================================================================
module bpc_div
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [DIV_W-1:0] in_num,
  input  logic [DIV_W-1:0] in_den,
  input  side_t            in_side,
  output logic [DIV_W-1:0] quo,
  output side_t            out_side
);

  logic [DIV_W-1:0] rem_r [DIV_W+1];
  logic [DIV_W-1:0] num_r [DIV_W+1];
  logic [DIV_W-1:0] den_r [DIV_W+1];
  side_t            side_r[DIV_W+1];

  logic [DIV_W-1:0] rem_nxt[DIV_W+1];
  logic [DIV_W-1:0] num_nxt[DIV_W+1];

  always_comb begin
    logic [DIV_W:0] r;
    rem_nxt[0] = '0;
    num_nxt[0] = in_num;
    for (int s = 1; s <= DIV_W; s++) begin
      r = {rem_r[s-1], num_r[s-1][DIV_W-1]};
      if (r >= {1'b0, den_r[s-1]}) begin
        rem_nxt[s] = DIV_W'(r - {1'b0, den_r[s-1]});
        num_nxt[s] = {num_r[s-1][DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt[s] = r[DIV_W-1:0];
        num_nxt[s] = {num_r[s-1][DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_W; s++) side_r[s].vld <= 1'b0;
    end else if (en) begin
      rem_r[0]  <= rem_nxt[0];
      num_r[0]  <= num_nxt[0];
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int s = 1; s <= DIV_W; s++) begin
        rem_r[s]  <= rem_nxt[s];
        num_r[s]  <= num_nxt[s];
        den_r[s]  <= den_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign quo      = num_r[DIV_W];
  assign out_side = side_r[DIV_W];

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Barometric compensation unit testbench
// Sends raw temperature and pressure requests under several calibration sets,
// predicts each compensated result with an independent integer model, and
// compares every returned field in order. Covers idle and stall patterns,
// long output back-pressure, zero divisors and clamping.
// ----------------------------------------------------------------------------
module testbench
  import bpc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int TAIL_CYCLES     = 100;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic signed [15:0] temp;
    logic [17:0]        press;
    logic [1:0]         status;
  } reading_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        in_raw_temp;
  logic [23:0]        in_raw_press;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_temperature_deci;
  logic [17:0]        out_pressure_pa;
  logic [1:0]         out_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  logic [31:0] cal [8];
  reading_t    pending_readings[$];
  int          fail_count = 0;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  logic        hold_off_req;
  int          hold_off_cycles = 0;
  int          quiet_cycles = 0;

  barometric_pressure_compensation_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint wrap32(input longint v);
    return longint'(int'(v));
  endfunction

  function automatic longint sext16(input logic [15:0] v);
    return longint'(shortint'(v));
  endfunction

  // Integer compensation of one reading pair under the current calibration.
  function automatic reading_t compensate_reading(input logic [15:0] rt,
                                                  input logic [23:0] rp);
    reading_t r;
    longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut, up;
    longint x1, x2, x3, d, b5, b6, sq, b3, t, p;
    bit [31:0] ac4, tmp, b4, b7, pu;
    int oss;
    ac1 = sext16(cal[REG_AC1][15:0]);
    ac2 = sext16(cal[REG_AC2][15:0]);
    ac3 = sext16(cal[REG_AC3][15:0]);
    ac4 = {16'd0, cal[REG_AC4][15:0]};
    ac5 = longint'(cal[REG_AC5_AC6][31:16]);
    ac6 = longint'(cal[REG_AC5_AC6][15:0]);
    b1  = sext16(cal[REG_B1_B2][31:16]);
    b2  = sext16(cal[REG_B1_B2][15:0]);
    mc  = sext16(cal[REG_MC_MD][31:16]);
    md  = sext16(cal[REG_MC_MD][15:0]);
    oss = int'(cal[REG_OSS][1:0]);
    ut  = longint'(rt);
    up  = longint'(rp >> (8 - oss));
    r.temp = '0; r.press = '0; r.status = ST_DIVZ;

    x1 = wrap32((ut - ac6) * ac5) / 32768;
    d  = wrap32(x1 + md);
    if (d == 0) return r;
    x2 = wrap32(wrap32(mc * 2048) / d);
    b5 = wrap32(x1 + x2);
    t  = wrap32(b5 + 8) / 16;

    b6 = wrap32(b5 - 4000);
    sq = wrap32(b6 * b6) / 4096;
    x1 = wrap32(b2 * sq) / 2048;
    x2 = wrap32(ac2 * b6) / 2048;
    x3 = wrap32(x1 + x2);
    b3 = wrap32(wrap32(wrap32(ac1 * 4 + x3) * (longint'(1) << oss)) + 2) / 4;
    x1 = wrap32(ac3 * b6) / 8192;
    x2 = wrap32(b1 * sq) / 65536;
    x3 = wrap32(x1 + x2 + 2) / 4;
    tmp = ac4 * x3[31:0] + ac4 * 32'd32768;
    b4  = tmp >> 15;
    if (b4 == 0) return r;
    b7 = (up[31:0] - b3[31:0]) * (32'd50000 >> oss);
    pu = (b7 < 32'h8000_0000) ? (b7 * 32'd2) / b4 : (b7 / b4) * 32'd2;
    p  = wrap32(longint'(pu));
    x1 = wrap32((p / 256) * (p / 256));
    x1 = wrap32(x1 * 3038) / 65536;
    x2 = wrap32(-7357 * p) / 65536;
    p  = wrap32(p + wrap32(x1 + x2 + 3791) / 16);

    r.status = ST_OK;
    if (t > 32767)  begin t = 32767;  r.status = ST_CLAMP; end
    if (t < -32768) begin t = -32768; r.status = ST_CLAMP; end
    if (p > 262143) begin p = 262143; r.status = ST_CLAMP; end
    if (p < 0)      begin p = 0;      r.status = ST_CLAMP; end
    r.temp  = t[15:0];
    r.press = p[17:0];
    return r;
  endfunction

  // Result checking against the oldest outstanding prediction.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (out_temperature_deci !== want.temp) begin
          $error("temperature_deci expected %0d got %0d", want.temp, out_temperature_deci);
          fail_count++;
        end
        if (out_pressure_pa !== want.press) begin
          $error("pressure_pa expected %0d got %0d", want.press, out_pressure_pa);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_off_cycles <= 0;
    end else if (hold_off_req) begin
      out_ready <= 1'b0;
      hold_off_cycles <= HOLD_OFF_CYCLES;
    end else if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_reading(input logic [15:0] rt, input logic [23:0] rp);
    int gap;
    in_valid     <= 1'b1;
    in_raw_temp  <= rt;
    in_raw_press <= rp;
    do @(posedge clk); while (!in_ready);
    pending_readings.push_back(compensate_reading(rt, rp));
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with no request in flight.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_AC1, REG_AC2, REG_AC3, REG_AC4: begin
        cal[idx] = {16'd0, data[15:0]};
      end
      REG_OSS: begin
        cal[idx] = {30'd0, data[1:0]};
      end
      default: begin
        cal[idx] = data;
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic restore_defaults();
    write_reg(REG_AC1, {16'd0, RST_AC1});
    write_reg(REG_AC2, {16'd0, RST_AC2});
    write_reg(REG_AC3, {16'd0, RST_AC3});
    write_reg(REG_AC4, {16'd0, RST_AC4});
    write_reg(REG_AC5_AC6, RST_AC5_AC6);
    write_reg(REG_B1_B2, RST_B1_B2);
    write_reg(REG_MC_MD, RST_MC_MD);
    write_reg(REG_OSS, 32'd0);
  endtask

  // A plausible sensor reading, or with some odds a fully random one.
  task automatic send_random_reading();
    logic [15:0] rt;
    logic [23:0] rp;
    if ($urandom_range(3) != 0) begin
      rt = 16'($urandom_range(40000, 15000));
      rp = 24'($urandom_range(45000, 15000)) << cal[REG_OSS][1:0] << (8 - cal[REG_OSS][1:0]);
      rp = rp | 24'($urandom_range(255) >> cal[REG_OSS][1:0]);
    end else begin
      rt = 16'($urandom);
      rp = 24'($urandom);
    end
    send_reading(rt, rp);
  endtask

  task automatic test_reset_calibration();
    send_reading(16'd27898, 24'd23843 << 8);
    send_reading(16'd0, 24'd0);
    send_reading(16'hFFFF, 24'hFFFFFF);
    send_reading(16'h8000, 24'h800000);
    send_reading(16'h7FFF, 24'h7FFFFF);
  endtask

  task automatic test_oversampling_modes();
    for (int m = 0; m < 4; m++) begin
      // Upper data bits must be dropped by the two-bit register.
      write_reg(REG_OSS, {30'h2AAAAAAA, 2'(m)});
      send_reading(16'd27898, 24'hFFFFFF);
      send_reading(16'd25000, 24'h5D2300);
    end
    write_reg(REG_OSS, 32'd0);
  endtask

  task automatic test_zero_divisors();
    // With AC5 and MD both zero the temperature divisor is zero.
    write_reg(REG_AC5_AC6, 32'h0000_5A3F);
    write_reg(REG_MC_MD, 32'hD4BD_0000);
    send_reading(16'd27898, 24'd23843 << 8);
    restore_defaults();
    // AC4 of zero makes the pressure divisor zero.
    write_reg(REG_AC4, 32'hFFFF_0000);
    send_reading(16'd27898, 24'd23843 << 8);
    send_reading(16'hFFFF, 24'h000000);
    restore_defaults();
  endtask

  task automatic test_calibration_extremes();
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 7; i++) write_reg(3'(i), k ? 32'hFFFF_FFFF : 32'h8000_8000);
      write_reg(REG_OSS, k ? 32'd3 : 32'd0);
      send_reading(16'd0, 24'h000000);
      send_reading(16'hFFFF, 24'hFFFFFF);
      send_reading(16'd27898, 24'd23843 << 8);
    end
    restore_defaults();
  endtask

  task automatic randomize_calibration(input bit wild);
    if (wild) begin
      for (int i = 0; i < 8; i++) write_reg(3'(i), $urandom);
    end else begin
      write_reg(REG_AC1, 32'($urandom_range(9000, 7000)));
      write_reg(REG_AC2, 32'(-$urandom_range(1200, 1000)));
      write_reg(REG_AC3, 32'(-$urandom_range(14800, 14000)));
      write_reg(REG_AC4, 32'($urandom_range(33000, 32500)));
      write_reg(REG_AC5_AC6, {16'($urandom_range(25000, 24000)),
                              16'($urandom_range(24000, 22000))});
      write_reg(REG_B1_B2, {16'($urandom_range(6400, 6000)), 16'($urandom_range(60, 0))});
      write_reg(REG_MC_MD, {16'(-$urandom_range(12000, 11000)),
                            16'($urandom_range(3000, 2000))});
      write_reg(REG_OSS, $urandom);
    end
  endtask

  task automatic test_random_traffic();
    int idle_pct [4] = '{0, 74, 0, 27};
    int stall_pct [4] = '{0, 0, 74, 27};
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_pct[ph];
      receiver_stall_pct = stall_pct[ph];
      for (int s = 0; s < 4; s++) begin
        randomize_calibration(s == 3);
        repeat (35) send_random_reading();
      end
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    randomize_calibration(1'b0);
    sender_idle_pct = 10;
    receiver_stall_pct = 20;
    hold_off_req <= 1'b1;
    @(posedge clk);
    hold_off_req <= 1'b0;
    repeat (150) send_random_reading();
    // Let everything come out before the sender continues.
    wait_drained();
    repeat (20) send_random_reading();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_temp = '0;
    in_raw_press = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_req = 1'b0;
    cal[REG_AC1] = {16'd0, RST_AC1};
    cal[REG_AC2] = {16'd0, RST_AC2};
    cal[REG_AC3] = {16'd0, RST_AC3};
    cal[REG_AC4] = {16'd0, RST_AC4};
    cal[REG_AC5_AC6] = RST_AC5_AC6;
    cal[REG_B1_B2] = RST_B1_B2;
    cal[REG_MC_MD] = RST_MC_MD;
    cal[REG_OSS] = 32'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_calibration();
    test_oversampling_modes();
    test_zero_divisors();
    test_calibration_extremes();
    test_random_traffic();
    test_output_backpressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
